[hw/rtl/fir_lp_pkg.sv]
// Shared sizes, command codes and queue entry type for the FIR low-pass filter.
`default_nettype none

package fir_lp_pkg;

  // Filter sizing
  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 18;
  localparam int FRAC_BITS   = 16;

  // Fixed field widths
  localparam int CMD_BITS      = 2;
  localparam int CIDX_BITS     = 6;
  localparam int TAP_REG_BITS  = 7;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // Derived widths
  localparam int AW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAPW      = $clog2(MAX_TAPS + 1);
  localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_FULL  = PROD_BITS + $clog2(MAX_TAPS + 1);
  localparam int ACC_BITS  = (ACC_FULL > 64) ? 64 : ACC_FULL;

  // Stream packing, each padded to whole bytes
  localparam int IN_FIELD_BITS = CIDX_BITS + COEF_BITS + SAMPLE_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_FILTER = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

  // Register map (word index taken from paddr[2])
  localparam logic REG_TAP_COUNT = 1'b0;
  localparam logic [TAP_REG_BITS-1:0] TAP_RESET = 7'd64;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_FILTER,
    OP_CLEAR
  } op_kind_e;

  typedef struct packed {
    op_kind_e                       kind;
    logic [AW-1:0]                  addr;
    logic signed [COEF_BITS-1:0]    coef;
    logic signed [SAMPLE_BITS-1:0]  sample;
  } op_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[hw/rtl/fir_lowpass_filter.sv]
// Top level of the FIR low-pass filter: stream ports, APB register and the front/back split.
`default_nettype none

// Direct-form FIR filter with up to MAX_TAPS (64) loadable coefficients. Load (tuser 0)
// writes one coefficient, filter (tuser 1) shifts a sample into the delay line and returns
// one result, clear (tuser 2) zeroes the history; code 3 and loads beyond the store are
// dropped. Once a registered out-of-reset flag is set, the front end takes one transfer per
// cycle into a four-entry queue as long as the queue has room. The back end runs one
// operation at a time; for a filter sample the single shared multiply-accumulate unit
// walks min(tap_count, 64) taps, none when tap_count is zero, one per cycle through the
// coefficient and history memories.
// The finished sample waits in an output register while the next
// operation is already under way. No clearing pass after reset: per-entry valid bits
// make both stores read as zero until written. tap_count lies at byte address 0, resets to
// 64 and is to be written only while the filter is idle.
module fir_lowpass_filter import fir_lp_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Input stream
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // coef_index, coef_value, sample_in
  input  wire logic [CMD_BITS-1:0]      s_axis_tuser,  // command
  // Result stream
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,  // sample_out
  output logic [0:0]                    m_axis_tuser,  // clipped
  // Register port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  logic [TAP_REG_BITS-1:0] tap_count_q;
  logic                    reg_idx;
  q_stat_t                 q_stat;
  logic                    push;
  op_t                     op_in;
  op_t                     op_head;
  logic                    pop;
  logic                    clip;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign prdata  = (reg_idx == REG_TAP_COUNT) ? CFG_DATA_BITS'(tap_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_TAP_COUNT) begin
      tap_count_q <= pwdata[TAP_REG_BITS-1:0];
    end
  end

  fir_lp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .op_o       (op_in)
  );

  fir_lp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (op_in),
    .pop_i  (pop),
    .op_o   (op_head),
    .stat_o (q_stat)
  );

  fir_lp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tap_count_i (tap_count_q),
    .op_valid_i  (~q_stat.empty),
    .op_i        (op_head),
    .op_pop_o    (pop),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tclip_o   (clip)
  );

  assign m_axis_tuser = clip;

endmodule

`default_nettype wire

[hw/rtl/fir_lp_front.sv]
// Front end: takes stream transfers, decodes the command and queues valid operations.
`default_nettype none

module fir_lp_front import fir_lp_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_tvalid_i,
  output logic                         s_tready_o,
  input  wire logic [IN_DATA_BITS-1:0] s_tdata_i,
  input  wire logic [CMD_BITS-1:0]     s_tuser_i,
  input  wire q_stat_t                 q_stat_i,
  output logic                         push_o,
  output op_t                          op_o
);

  logic                 xfer;
  logic                 keep;
  logic [CIDX_BITS-1:0] idx;
  logic                 seen_q;

  // No transfer is taken before the first edge out of reset
  assign s_tready_o = seen_q & ~q_stat_i.full;
  assign xfer       = s_tvalid_i & s_tready_o;
  assign idx        = s_tdata_i[CIDX_BITS-1:0];

  // Field unpacking and command decode; unused code and out-of-range loads are dropped here
  always_comb begin
    op_o.addr   = AW'(idx);
    op_o.coef   = s_tdata_i[CIDX_BITS +: COEF_BITS];
    op_o.sample = s_tdata_i[CIDX_BITS+COEF_BITS +: SAMPLE_BITS];
    keep        = 1'b0;
    op_o.kind   = OP_FILTER;
    unique case (s_tuser_i)
      CMD_LOAD: begin
        op_o.kind = OP_LOAD;
        keep      = (int'(idx) < MAX_TAPS);
      end
      CMD_FILTER: begin
        op_o.kind = OP_FILTER;
        keep      = 1'b1;
      end
      CMD_CLEAR: begin
        op_o.kind = OP_CLEAR;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = xfer & keep;

  // Out of reset once the first clock edge has passed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fir_lp_fifo.sv]
// Short operation queue between the front end and the MAC engine.
`default_nettype none

module fir_lp_fifo import fir_lp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  input  wire logic pop_i,
  output op_t       op_o,
  output q_stat_t   stat_o
);

  op_t            mem_q [QDEPTH];
  logic [QAW-1:0] wr_q;
  logic [QAW-1:0] rd_q;
  logic [QAW:0]   cnt_q;
  logic           do_push;
  logic           do_pop;

  assign stat_o.full  = (cnt_q == (QAW+1)'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign op_o         = mem_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= op_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fir_lp_back.sv]
// Back end: coefficient and history stores, shared MAC sequencer, rounding and result register.
`default_nettype none

module fir_lp_back import fir_lp_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [TAP_REG_BITS-1:0]  tap_count_i,
  input  wire logic                     op_valid_i,
  input  wire op_t                      op_i,
  output logic                          op_pop_o,
  output logic                          m_tvalid_o,
  input  wire logic                     m_tready_i,
  output logic [OUT_DATA_BITS-1:0]      m_tdata_o,
  output logic                          m_tclip_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_e;

  localparam logic signed [ACC_BITS-1:0] RND  = ACC_BITS'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [ACC_BITS-1:0] SMAX = ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] SMIN = -SMAX - 1;

  // Stores
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]           coef_vld_q;
  logic [MAX_TAPS-1:0]           hist_vld_q;

  state_e                        state_q;
  logic [AW-1:0]                 wp_q;
  logic [AW-1:0]                 rp_q;
  logic [TAPW-1:0]               k_q;
  logic [TAPW-1:0]               taps;
  logic [AW-1:0]                 wp_nxt;
  logic [AW-1:0]                 rp_nxt;
  logic                          issue;

  // Pipeline registers
  logic                          s1_vld_q;
  logic                          cv_q;
  logic                          hv_q;
  logic signed [COEF_BITS-1:0]   c_rd_q;
  logic signed [SAMPLE_BITS-1:0] h_rd_q;
  logic signed [COEF_BITS-1:0]   mul_c;
  logic signed [SAMPLE_BITS-1:0] mul_s;
  logic                          s2_vld_q;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic signed [ACC_BITS-1:0]    acc_q;

  // Rounding and saturation
  logic signed [ACC_BITS-1:0]    rnd_sum;
  logic signed [ACC_BITS-1:0]    y_full;
  logic [SAMPLE_BITS-1:0]        y_sat;
  logic                          y_clip;

  // Result register
  logic                          out_vld_q;
  logic [SAMPLE_BITS-1:0]        out_data_q;
  logic                          out_clip_q;
  logic                          out_load;

  // Effective tap count, limited to the store depth
  always_comb begin
    if (int'(tap_count_i) > MAX_TAPS) begin
      taps = TAPW'(MAX_TAPS);
    end else begin
      taps = TAPW'(tap_count_i);
    end
  end

  assign wp_nxt   = (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
  assign rp_nxt   = (rp_q == '0) ? AW'(MAX_TAPS - 1) : rp_q - 1'b1;
  assign op_pop_o = (state_q == ST_IDLE) & op_valid_i;
  assign issue    = (state_q == ST_MAC);

  assign mul_c = cv_q ? c_rd_q : '0;
  assign mul_s = hv_q ? h_rd_q : '0;

  // Round half up, shift out the fraction, clamp to sample range
  always_comb begin
    rnd_sum = acc_q + RND;
    y_full  = rnd_sum >>> FRAC_BITS;
    y_clip  = 1'b0;
    if (y_full > SMAX) begin
      y_sat  = SMAX[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end else if (y_full < SMIN) begin
      y_sat  = SMIN[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end else begin
      y_sat  = y_full[SAMPLE_BITS-1:0];
    end
  end

  assign out_load = (state_q == ST_DONE) & (~out_vld_q | m_tready_i);

  // Store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (op_pop_o && op_i.kind == OP_LOAD) begin
      coef_mem[op_i.addr] <= op_i.coef;
    end
    if (op_pop_o && op_i.kind == OP_FILTER) begin
      hist_mem[wp_nxt] <= op_i.sample;
    end
    if (issue) begin
      c_rd_q <= coef_mem[k_q[AW-1:0]];
      h_rd_q <= hist_mem[rp_q];
    end
    if (s1_vld_q) begin
      prod_q <= mul_c * mul_s;
    end
    if (out_load) begin
      out_data_q <= y_sat;
      out_clip_q <= y_clip;
    end
  end

  // Sequencer, valid bits, accumulator and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wp_q       <= '0;
      rp_q       <= '0;
      k_q        <= '0;
      coef_vld_q <= '0;
      hist_vld_q <= '0;
      s1_vld_q   <= 1'b0;
      cv_q       <= 1'b0;
      hv_q       <= 1'b0;
      s2_vld_q   <= 1'b0;
      acc_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (issue) begin
        cv_q <= coef_vld_q[k_q[AW-1:0]];
        hv_q <= hist_vld_q[rp_q];
      end
      if (s2_vld_q) begin
        acc_q <= acc_q + ACC_BITS'(prod_q);
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (op_pop_o) begin
            unique case (op_i.kind)
              OP_LOAD: begin
                coef_vld_q[op_i.addr] <= 1'b1;
              end
              OP_CLEAR: begin
                hist_vld_q <= '0;
              end
              OP_FILTER: begin
                hist_vld_q[wp_nxt] <= 1'b1;
                wp_q               <= wp_nxt;
                rp_q               <= wp_nxt;
                k_q                <= '0;
                acc_q              <= '0;
                state_q            <= (taps == '0) ? ST_DRAIN : ST_MAC;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MAC: begin
          k_q  <= k_q + 1'b1;
          rp_q <= rp_nxt;
          if (k_q + 1'b1 == taps) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_vld_q && !s2_vld_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = OUT_DATA_BITS'(out_data_q);
  assign m_tclip_o  = out_clip_q;

endmodule

`default_nettype wire

[hw/rtl/fir_lp_checker.sv]
// Port-level checks for the FIR low-pass filter, bound to the top level.
`default_nettype none

module fir_lp_checker import fir_lp_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     m_axis_tvalid,
  input wire logic                     m_axis_tready,
  input wire logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  input wire logic [0:0]               m_axis_tuser,
  input wire logic                     psel,
  input wire logic                     penable,
  input wire logic                     pwrite,
  input wire logic                     pready,
  input wire logic [CFG_ADDR_BITS-1:0] paddr,
  input wire logic [CFG_DATA_BITS-1:0] pwdata,
  input wire logic [CFG_DATA_BITS-1:0] prdata
);

  localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A clipped result sits at one of the range limits
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[SAMPLE_BITS-1:0] == SAT_HI || m_axis_tdata[SAMPLE_BITS-1:0] == SAT_LO))
    else $error("clip flag without saturated value");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Tap count reads back what was last written
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] == REG_TAP_COUNT |=>
      (paddr[2] != REG_TAP_COUNT ||
       prdata[TAP_REG_BITS-1:0] == $past(pwdata[TAP_REG_BITS-1:0])))
    else $error("tap count readback mismatch");

endmodule

bind fir_lowpass_filter fir_lp_checker u_fir_lp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .pready        (pready),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

`default_nettype wire

[bench/fir_lp_checker.sv]
// Checker for the FIR low-pass filter: follows both streams and the register port, predicts results.
module fir_lp_scoreboard import fir_lp_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  input  wire logic                     s_axis_tready,
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // coef_index, coef_value, sample_in
  input  wire logic [CMD_BITS-1:0]      s_axis_tuser,  // command
  input  wire logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  input  wire logic [OUT_DATA_BITS-1:0] m_axis_tdata,  // sample_out
  input  wire logic [0:0]               m_axis_tuser,  // clipped
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic                     pready,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output int                            error_count_o,
  output int                            outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] level;
    logic                          clipped;
  } fir_out_t;

  // Own copy of the filter state
  logic signed [COEF_BITS-1:0]   coef_mem   [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] delay_line [MAX_TAPS];
  logic [TAP_REG_BITS-1:0]       taps_in_use;
  fir_out_t                      filtered_q [$];

  int errors  = 0;
  int waiting = 0;

  assign error_count_o = errors;
  assign outstanding_o = waiting;

  // Shift a sample in and form the rounded, saturated dot product
  function automatic fir_out_t filter_step(input logic signed [SAMPLE_BITS-1:0] smp);
    longint   acc;
    longint   y;
    longint   top;
    int       n;
    fir_out_t res;
    for (int j = MAX_TAPS - 1; j > 0; j--) delay_line[j] = delay_line[j-1];
    delay_line[0] = smp;
    n = (taps_in_use > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
    res = '0;
    if (n == 0) return res;
    acc = 0;
    for (int j = 0; j < n; j++) acc += longint'(coef_mem[j]) * longint'(delay_line[j]);
    // half rounds toward plus infinity, shift is a floor
    acc += longint'(1) << (FRAC_BITS - 1);
    y   = acc >>> FRAC_BITS;
    top = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    if (y > top) begin
      y = top;
      res.clipped = 1'b1;
    end else if (y < -top - 1) begin
      y = -top - 1;
      res.clipped = 1'b1;
    end
    res.level = y[SAMPLE_BITS-1:0];
    return res;
  endfunction

  // Follow register writes and input transfers, compare result transfers
  always @(posedge clk_i or negedge rst_ni) begin : follow_proc
    fir_out_t want;
    if (!rst_ni) begin
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (delay_line[i]) delay_line[i] = '0;
      taps_in_use = TAP_RESET;
      filtered_q.delete();
      waiting = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_TAP_COUNT)
        taps_in_use = pwdata[TAP_REG_BITS-1:0];
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          CMD_LOAD: begin
            coef_mem[s_axis_tdata[CIDX_BITS-1:0]] = s_axis_tdata[CIDX_BITS +: COEF_BITS];
          end
          CMD_FILTER: begin
            want = filter_step(s_axis_tdata[CIDX_BITS+COEF_BITS +: SAMPLE_BITS]);
            filtered_q.insert(filtered_q.size(), want);
          end
          CMD_CLEAR: begin
            foreach (delay_line[i]) delay_line[i] = '0;
          end
          default: ;  // unused code, dropped
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          errors++;
          $error("result transfer with none due: sample_out %0d clipped %0b",
                 $signed(m_axis_tdata[SAMPLE_BITS-1:0]), m_axis_tuser[0]);
        end else begin
          want = filtered_q.pop_front();
          if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.level) begin
            errors++;
            $error("sample_out: expected %0d, got %0d", want.level,
                   $signed(m_axis_tdata[SAMPLE_BITS-1:0]));
          end
          if (m_axis_tuser[0] !== want.clipped) begin
            errors++;
            $error("clipped: expected %0b, got %0b", want.clipped, m_axis_tuser[0]);
          end
        end
      end
      waiting = filtered_q.size();
    end
  end

  // Filter samples still owed a result at the end
  final begin
    if (filtered_q.size() != 0)
      $error("filtered results never delivered: %0d", filtered_q.size());
  end

endmodule

[bench/tb.sv]
// Testbench top for the FIR low-pass filter: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fir_lp_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 100;  // queued loads and clears drain well within this
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_OPS    = 160;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;  // coef_index, coef_value, sample_in
  logic [CMD_BITS-1:0]      s_axis_tuser  = '0;  // command
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;        // sample_out
  logic [0:0]               m_axis_tuser;        // clipped
  logic                     psel          = 1'b0;
  logic                     penable       = 1'b0;
  logic                     pwrite        = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr         = '0;
  logic [CFG_DATA_BITS-1:0] pwdata        = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  int fail_count;
  int results_due;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  fir_lowpass_filter i_dut (.*);

  fir_lp_scoreboard i_checker (
    .*,
    .error_count_o (fail_count),
    .outstanding_o (results_due)
  );

  always #4 clk_i = ~clk_i;

  // Result side back-pressure
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  // One input transfer, with random idle cycles in front
  task automatic send_op(input logic [CMD_BITS-1:0] cmd, input int idx, input int coef,
                         input int smp);
    logic [IN_DATA_BITS-1:0] word;
    word = '0;
    word[CIDX_BITS-1:0]                      = idx[CIDX_BITS-1:0];
    word[CIDX_BITS +: COEF_BITS]             = coef[COEF_BITS-1:0];
    word[CIDX_BITS+COEF_BITS +: SAMPLE_BITS] = smp[SAMPLE_BITS-1:0];
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Let the filter go idle, then write tap_count with junk in the upper bits
  task automatic write_taps(input int value);
    logic [CFG_DATA_BITS-1:0] word;
    word = $urandom;
    word[TAP_REG_BITS-1:0] = value[TAP_REG_BITS-1:0];
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (results_due == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TAP_COUNT, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly low-pass sized coefficients, some full range
  function automatic int rand_coef();
    if ($urandom_range(3) == 0) return int'($urandom_range(262143)) - 131072;
    return int'($urandom_range(8191)) - 4096;
  endfunction

  function automatic int rand_sample();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 32767;
    if (r == 1) return -32768;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Random mix: mostly samples, some reloads, clears and unused codes
  task automatic random_op();
    int r;
    int burst;
    r = $urandom_range(99);
    if (r < 6) begin
      send_op(CMD_CLEAR, $urandom, $urandom, $urandom);
    end else if (r < 9) begin
      send_op(CMD_UNUSED, $urandom, $urandom, $urandom);
    end else if (r < 12) begin
      // short run of coefficient updates from a random start
      burst = $urandom_range(63);
      for (int k = 0; k < 8; k++)
        send_op(CMD_LOAD, burst + k, rand_coef(), $urandom);
    end else if (r < 24) begin
      send_op(CMD_LOAD, $urandom, rand_coef(), $urandom);
    end else begin
      send_op(CMD_FILTER, $urandom, $urandom, rand_sample());
    end
  endtask

  // Stimulus and verdict
  initial begin
    int phase_taps [8];
    int src_pct    [4];
    int sink_pct   [4];
    phase_taps = '{1, 64, 0, 127, 2, 65, 0, 0};
    phase_taps[6] = $urandom_range(1, 64);
    phase_taps[7] = $urandom_range(127);
    src_pct  = '{0, 57, 0, 27};
    sink_pct = '{0, 0, 57, 27};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero store, saturation both ways, rounding ties, clear, unused code
    send_op(CMD_FILTER, 0, 0, 1000);
    send_op(CMD_LOAD, 0, 131071, 0);
    send_op(CMD_LOAD, 63, -131072, 0);
    send_op(CMD_FILTER, 63, -1, 32767);
    send_op(CMD_FILTER, 0, 0, -32768);
    send_op(CMD_CLEAR, 0, 0, 0);
    send_op(CMD_FILTER, 0, 0, 0);
    send_op(CMD_LOAD, 0, 32768, 0);
    send_op(CMD_FILTER, 0, 0, 1);
    send_op(CMD_FILTER, 0, 0, -1);
    send_op(CMD_FILTER, 0, 0, 3);
    send_op(CMD_FILTER, 0, 0, -3);
    send_op(CMD_UNUSED, -1, -1, -1);
    send_op(CMD_LOAD, 1, -1, -1);
    send_op(CMD_FILTER, 0, 0, -32768);
    // no taps: result zero, sample still shifted in
    write_taps(0);
    send_op(CMD_FILTER, 0, 0, 12345);
    send_op(CMD_FILTER, 0, 0, -32768);
    // above store depth saturates to the full store
    write_taps(127);
    send_op(CMD_FILTER, 0, 0, 32767);
    send_op(CMD_FILTER, 0, 0, 0);

    // Random phases, each with its own tap count and idling pattern
    for (int p = 0; p < 8; p++) begin
      write_taps(phase_taps[p]);
      src_idle_pct   = src_pct[p % 4];
      sink_stall_pct = sink_pct[p % 4];
      for (int k = 0; k < MAX_TAPS; k++) send_op(CMD_LOAD, k, rand_coef(), $urandom);
      for (int k = 0; k < RANDOM_OPS; k++) random_op();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (results_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs and reports it as failed
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
